FILE: sv/jts_pkg.sv
`timescale 1ns / 1ps

package jts_pkg;

    // scanner states: accepting states are token kind plus one
    typedef enum logic [3:0] {
        ST_START = 4'd0,
        ST_ID    = 4'd1,
        ST_QUOTE = 4'd2,
        ST_COLON = 4'd3,
        ST_NUM   = 4'd4,
        ST_SPACE = 4'd5,
        ST_LBRK  = 4'd6,
        ST_RBRK  = 4'd7,
        ST_LBRC  = 4'd8,
        ST_RBRC  = 4'd9,
        ST_COMMA = 4'd10,
        ST_ESC   = 4'd11,
        ST_NONE  = 4'd15
    } scan_state_t;

    typedef enum logic [1:0] {
        EV_CHAR    = 2'd0,
        EV_END     = 2'd1,
        EV_ERR     = 2'd2,
        EV_DISCARD = 2'd3
    } ev_kind_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_RBRC   = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [3:0] token_kind;
        logic [7:0] lexeme_char;
        logic       last_of_run;
    } out_item_t;

    // one result inside a bundle
    typedef struct packed {
        ev_kind_t   event_kind;
        logic [3:0] token_kind;
        logic [7:0] lexeme_char;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [1:0]              count;
        res_t [MAX_RES-1:0]      res;
    } bundle_t;

    function automatic logic is_accepting(input scan_state_t s);
        return (s >= ST_ID) && (s <= ST_COMMA);
    endfunction

    function automatic logic [3:0] kind_of(input scan_state_t s);
        return is_accepting(s) ? (4'(s) - 4'd1) : 4'd0;
    endfunction

    // transition table of the scanner
    function automatic scan_state_t next_state(input scan_state_t s, input logic [7:0] c);
        logic        digit;
        scan_state_t ns;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        ns = ST_NONE;
        if (!c[7]) begin
            unique case (s)
                ST_START: begin
                    if (digit) begin
                        ns = ST_NUM;
                    end else begin
                        unique case (c)
                            CH_QUOTE: ns = ST_QUOTE;
                            CH_COLON: ns = ST_COLON;
                            CH_LBRK:  ns = ST_LBRK;
                            CH_RBRK:  ns = ST_RBRK;
                            CH_LBRC:  ns = ST_LBRC;
                            CH_RBRC:  ns = ST_RBRC;
                            CH_SPACE: ns = ST_SPACE;
                            CH_COMMA: ns = ST_COMMA;
                            default:  ns = ST_ID;
                        endcase
                    end
                end
                ST_ID: begin
                    if (c == CH_QUOTE) begin
                        ns = ST_NONE;
                    end else if (c == CH_BSLASH) begin
                        ns = ST_ESC;
                    end else begin
                        ns = ST_ID;
                    end
                end
                ST_ESC:  ns = ST_ID;
                ST_NUM:  ns = digit ? ST_NUM : ST_NONE;
                default: ns = ST_NONE;
            endcase
        end
        return ns;
    endfunction

endpackage

FILE: sv/json_token_scanner_core.sv
`timescale 1ns / 1ps

// channel  | direction | signals                   | payload
// s_       | in        | s_valid, s_ready, s_data  | in_item_t  (char_in, end_of_text)
// m_       | out       | m_valid, m_ready, m_data  | out_item_t (event_kind .. last_of_run)
//
// each byte is classified in the cycle it transfers; 0 to 3 results follow
// results leave one per cycle from the back end while m_ready is high
// a bundle queue of QUEUE_DEPTH entries lets input run ahead of a stalled output
// aresetn is synchronous: scanner returns to start, queue and output are emptied

module json_token_scanner_core
    import jts_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic    q_full;
    logic    push;
    bundle_t push_data;
    logic    pop_valid;
    logic    pop_ready;
    bundle_t pop_data;

    // classify bytes
    jts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // bundle queue
    jts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    // stream results
    jts_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: sv/jts_front.sv
`timescale 1ns / 1ps

module jts_front
    import jts_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     push,
    output bundle_t  push_data
);

    scan_state_t state_reg, state_next;
    logic        halted_reg, halted_next;
    logic        xfer;

    assign s_ready = !q_full;
    assign xfer    = s_valid && s_ready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_START;
            halted_reg <= 1'b0;
        end else if (xfer) begin
            state_reg  <= state_next;
            halted_reg <= halted_next;
        end
    end

    // classify the byte and build its result bundle
    always_comb begin
        logic [7:0]  c;
        logic        eot;
        logic        err;
        logic [1:0]  n;
        scan_state_t s;
        scan_state_t ns;
        c   = s_data.char_in;
        eot = s_data.end_of_text;
        err = 1'b0;
        n   = 2'd0;
        s   = state_reg;
        ns  = ST_NONE;
        push_data = '0;
        state_next  = state_reg;
        halted_next = halted_reg;
        if (halted_reg) begin
            if (eot) begin
                state_next  = ST_START;
                halted_next = 1'b0;
            end
        end else begin
            ns = next_state(s, c);
            if (ns == ST_NONE) begin
                if (is_accepting(s)) begin
                    push_data.res[n] = '{event_kind: EV_END, token_kind: kind_of(s),
                                         lexeme_char: 8'd0};
                    n  = n + 2'd1;
                    s  = ST_START;
                    ns = next_state(ST_START, c);
                end
                if (ns == ST_NONE) begin
                    push_data.res[n] = '{event_kind: EV_ERR, token_kind: 4'd0,
                                         lexeme_char: c};
                    n   = n + 2'd1;
                    err = 1'b1;
                    s   = ST_START;
                end
            end
            if (!err) begin
                s = ns;
                if (s != ST_ESC) begin
                    push_data.res[n] = '{event_kind: EV_CHAR, token_kind: kind_of(s),
                                         lexeme_char: c};
                    n = n + 2'd1;
                end
            end
            // end of text closes or discards the open token
            if (eot) begin
                if (!err) begin
                    if (is_accepting(s)) begin
                        push_data.res[n] = '{event_kind: EV_END, token_kind: kind_of(s),
                                             lexeme_char: 8'd0};
                        n = n + 2'd1;
                    end else if (s != ST_START) begin
                        push_data.res[n] = '{event_kind: EV_DISCARD, token_kind: 4'd0,
                                             lexeme_char: 8'd0};
                        n = n + 2'd1;
                    end
                end
                state_next  = ST_START;
                halted_next = 1'b0;
            end else begin
                state_next  = s;
                halted_next = err;
            end
        end
        push_data.count = n;
        push = xfer && (n != 2'd0);
    end

    a_no_push_when_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !halted_reg)
        else $error("front produced results while halted");

endmodule

FILE: sv/jts_queue.sv
`timescale 1ns / 1ps

module jts_queue
    import jts_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    output logic    pop_valid,
    input  logic    pop_ready,
    output bundle_t pop_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    bundle_t       slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          pop;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue written while full");

endmodule

FILE: sv/jts_back.sv
`timescale 1ns / 1ps

module jts_back
    import jts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  bundle_t   pop_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    bundle_t    bundle_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       last;
    logic       xfer;
    res_t       cur;

    assign cur       = bundle_reg.res[idx_reg];
    assign last      = (idx_reg == (bundle_reg.count - 2'd1));
    assign xfer      = busy_reg && m_ready;
    assign pop_ready = !busy_reg || (xfer && last);

    assign m_valid            = busy_reg;
    assign m_data.event_kind  = cur.event_kind;
    assign m_data.token_kind  = cur.token_kind;
    assign m_data.lexeme_char = cur.lexeme_char;
    assign m_data.last_of_run = last;

    // current bundle
    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            bundle_reg <= pop_data;
        end
    end

    // result sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (pop_valid && pop_ready) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (xfer) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    a_bundle_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (bundle_reg.count != 2'd0))
        else $error("empty bundle in back end");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg < bundle_reg.count))
        else $error("result index past bundle count");

endmodule

FILE: dv/jts_checker.sv
`timescale 1ns / 1ps

module jts_checker
    import jts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        pending
);

    localparam int REPORT_LIMIT = 10;

    scan_state_t lex_state      = ST_START;
    logic        lex_halted     = 1'b0;
    out_item_t   expected_events[$];
    int          mismatch_count = 0;

    // states 1..10 hold a complete token, escape and unused codes do not
    function automatic logic holds_token(scan_state_t s);
        return (s != ST_START) && (s < ST_ESC);
    endfunction

    function automatic logic [3:0] token_of(scan_state_t s);
        logic [3:0] code;
        code = s;
        return holds_token(s) ? code - 4'd1 : 4'd0;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // state entered from start on the leading byte of a token
    function automatic scan_state_t open_token(logic [7:0] c);
        if (is_digit(c)) begin
            return ST_NUM;
        end
        case (c)
            CH_QUOTE: return ST_QUOTE;
            CH_COLON: return ST_COLON;
            CH_LBRK:  return ST_LBRK;
            CH_RBRK:  return ST_RBRK;
            CH_LBRC:  return ST_LBRC;
            CH_RBRC:  return ST_RBRC;
            CH_SPACE: return ST_SPACE;
            CH_COMMA: return ST_COMMA;
            default:  return ST_ID;
        endcase
    endfunction

    // one step of the scanner, ST_NONE when the byte has no transition
    function automatic scan_state_t advance(scan_state_t s, logic [7:0] c);
        scan_state_t ns;
        ns = ST_NONE;
        if (!c[7]) begin
            case (s)
                ST_START: ns = open_token(c);
                ST_ID: begin
                    if (c == CH_QUOTE) begin
                        ns = ST_NONE;
                    end else if (c == CH_BSLASH) begin
                        ns = ST_ESC;
                    end else begin
                        ns = ST_ID;
                    end
                end
                ST_ESC:  ns = ST_ID;
                ST_NUM:  ns = is_digit(c) ? ST_NUM : ST_NONE;
                default: ns = ST_NONE;
            endcase
        end
        return ns;
    endfunction

    function automatic out_item_t make_event(ev_kind_t ev, logic [3:0] tok, logic [7:0] ch);
        out_item_t r;
        r.event_kind  = ev;
        r.token_kind  = tok;
        r.lexeme_char = ch;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // expected results of one byte transfer, appended to the expected queue
    task automatic predict_tokens(in_item_t it);
        out_item_t   burst[$];
        scan_state_t cur;
        scan_state_t nxt;
        logic        fault;
        logic [7:0]  c;
        c = it.char_in;
        // halted after an error: bytes are dropped until end of text
        if (lex_halted) begin
            if (it.end_of_text) begin
                lex_halted = 1'b0;
                lex_state  = ST_START;
            end
            return;
        end
        cur   = lex_state;
        fault = 1'b0;
        nxt   = advance(cur, c);
        // no transition: close an accepting token and retry from start
        if (nxt == ST_NONE) begin
            if (holds_token(cur)) begin
                burst.push_back(make_event(EV_END, token_of(cur), 8'd0));
                nxt = advance(ST_START, c);
            end
            if (nxt == ST_NONE) begin
                burst.push_back(make_event(EV_ERR, 4'd0, c));
                fault = 1'b1;
                cur   = ST_START;
            end
        end
        // the escaping backslash itself produces no lexeme char
        if (!fault) begin
            cur = nxt;
            if (cur != ST_ESC) begin
                burst.push_back(make_event(EV_CHAR, token_of(cur), c));
            end
        end
        if (it.end_of_text) begin
            if (!fault) begin
                if (holds_token(cur)) begin
                    burst.push_back(make_event(EV_END, token_of(cur), 8'd0));
                end else if (cur != ST_START) begin
                    burst.push_back(make_event(EV_DISCARD, 4'd0, 8'd0));
                end
            end
            lex_state  = ST_START;
            lex_halted = 1'b0;
        end else begin
            lex_state  = cur;
            lex_halted = fault;
        end
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last_of_run = 1'b1;
        end
        foreach (burst[i]) begin
            expected_events.push_back(burst[i]);
        end
    endtask

    // compare result transfers, then predict from byte transfers
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            lex_state  = ST_START;
            lex_halted = 1'b0;
            expected_events.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result ev=%0d tok=%0d ch=%02h last=%0d",
                                 $realtime, m_data.event_kind, m_data.token_kind,
                                 m_data.lexeme_char, m_data.last_of_run);
                    end
                end else begin
                    want = expected_events.pop_front();
                    if ((m_data.event_kind !== want.event_kind) ||
                        (m_data.token_kind !== want.token_kind) ||
                        (m_data.lexeme_char !== want.lexeme_char) ||
                        (m_data.last_of_run !== want.last_of_run)) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch expected ev=%0d tok=%0d ch=%02h last=%0d",
                                     $realtime, want.event_kind, want.token_kind,
                                     want.lexeme_char, want.last_of_run);
                            $display("%0t:          actual   ev=%0d tok=%0d ch=%02h last=%0d",
                                     $realtime, m_data.event_kind, m_data.token_kind,
                                     m_data.lexeme_char, m_data.last_of_run);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_tokens(s_data);
            end
        end
        fail_count <= mismatch_count;
        pending    <= expected_events.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import jts_pkg::*;
;

    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 32;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } rx_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        burst_left  = 0;
    int        random_sent = 0;
    logic      mid_pause_done = 1'b0;
    in_item_t  text_buf[$];
    rx_mode_t  rx_mode = RX_OPEN;
    logic [7:0] rx_tick = '0;

    json_token_scanner_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    jts_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall pattern, mode is redrawn whenever rx_tick[5:0] is zero
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_tick[5:0] == 6'd0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:  m_ready <= 1'b1;
            RX_COIN:  m_ready <= 1'($urandom_range(0, 1));
            RX_SLOW:  m_ready <= ($urandom_range(0, 4) == 0);
            default:  m_ready <= rx_tick[2];
        endcase
    end

    function automatic logic is_punct(logic [7:0] c);
        case (c)
            CH_QUOTE, CH_COLON, CH_LBRK, CH_RBRK,
            CH_LBRC, CH_RBRC, CH_SPACE, CH_COMMA: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 7))
            0:       return CH_QUOTE;
            1:       return CH_COLON;
            2:       return CH_LBRK;
            3:       return CH_RBRK;
            4:       return CH_LBRC;
            5:       return CH_RBRC;
            6:       return CH_SPACE;
            default: return CH_COMMA;
        endcase
    endfunction

    // 7-bit byte that opens an identifier
    function automatic logic [7:0] id_lead();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 127));
        end while (is_punct(c) || ((c >= CH_ZERO) && (c <= CH_NINE)));
        return c;
    endfunction

    // identifier body byte: anything 7-bit but a quote, backslash fairly often
    function automatic logic [7:0] id_body();
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0) begin
            return CH_BSLASH;
        end
        do begin
            c = 8'($urandom_range(0, 127));
        end while (c == CH_QUOTE);
        return c;
    endfunction

    // one byte transfer with bursty sender gaps
    task automatic send_item(in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_char(logic [7:0] c, logic eot);
        in_item_t it;
        it.char_in     = c;
        it.end_of_text = eot;
        send_item(it);
    endtask

    // stop sending until every expected result has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic add_byte(logic [7:0] c);
        in_item_t it;
        it.char_in     = c;
        it.end_of_text = 1'b0;
        text_buf.push_back(it);
    endtask

    // mostly well-formed text: punctuation, numbers and identifiers, most closed by a quote
    task automatic build_text();
        int         tokens;
        int         n;
        logic [7:0] c;
        tokens = $urandom_range(1, 8);
        repeat (tokens) begin
            case ($urandom_range(0, 3))
                0: add_byte(pick_punct());
                1: begin
                    n = $urandom_range(1, 4);
                    repeat (n) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                default: begin
                    add_byte(id_lead());
                    n = $urandom_range(0, 5);
                    repeat (n) begin
                        c = id_body();
                        add_byte(c);
                        if (c == CH_BSLASH) begin
                            if ($urandom_range(0, 9) == 0) begin
                                add_byte(8'($urandom_range(0, 255)));
                            end else begin
                                add_byte(8'($urandom_range(0, 127)));
                            end
                        end
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        add_byte(CH_QUOTE);
                    end
                end
            endcase
        end
        text_buf[text_buf.size() - 1].end_of_text = 1'b1;
    endtask

    // noise and broken texts: high bytes, stray escapes, odd end marks
    task automatic build_noise();
        int         n;
        logic [7:0] c;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       c = 8'($urandom_range(0, 255));
                1:       c = CH_BSLASH;
                2:       c = 8'($urandom_range(128, 255));
                default: c = 8'($urandom_range(0, 127));
            endcase
            add_byte(c);
            if ($urandom_range(0, 7) == 0) begin
                text_buf[text_buf.size() - 1].end_of_text = 1'b1;
            end
        end
        if ($urandom_range(0, 3) != 0) begin
            text_buf[text_buf.size() - 1].end_of_text = 1'b1;
        end
    endtask

    task automatic send_text();
        foreach (text_buf[i]) begin
            send_item(text_buf[i]);
        end
        random_sent += text_buf.size();
        text_buf.delete();
    endtask

    // stimulus and verdict
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // every token kind, escaped quote, low byte inside an identifier
        send_char(CH_LBRC, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(CH_BSLASH, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(CH_COLON, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_NINE, 1'b0);
        send_char(CH_ZERO, 1'b0);
        send_char(CH_COMMA, 1'b0);
        send_char(CH_LBRK, 1'b0);
        send_char(CH_RBRK, 1'b0);
        send_char(CH_RBRC, 1'b1);
        // text ending on a pending escape is discarded
        send_char(8'h78, 1'b0);
        send_char(CH_BSLASH, 1'b1);
        // number closed by a high byte, then halted until end of text
        send_char(8'h35, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h71, 1'b0);
        send_char(8'h7f, 1'b1);
        // error on the final byte
        send_char(8'hff, 1'b1);
        // single-byte identifier closed by end of text
        send_char(8'h7f, 1'b1);
        // high byte while waiting for an escaped byte
        send_char(8'h7a, 1'b0);
        send_char(CH_BSLASH, 1'b0);
        send_char(8'hc3, 1'b0);
        send_char(8'h61, 1'b1);
        hold_until_drained();

        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                build_noise();
            end else begin
                build_text();
            end
            send_text();
            if (!mid_pause_done && (random_sent >= RANDOM_ITEMS / 2)) begin
                hold_until_drained();
                mid_pause_done = 1'b1;
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if ((fail_count == 0) && (pending == 0)) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
